FILE: rtl/sas_pkg.sv
// stable argsort shared constants: store depth, compare width, field widths
// no dependencies; imported by sas_mem and stable_argsort
package sas_pkg;

  // default capacity of the sort store
  localparam int unsigned SAS_MAX_ITEMS   = 64;
  // default compare width of the fitness value
  localparam int unsigned SAS_VALUE_WIDTH = 32;
  // width of the value field on the input stream
  localparam int unsigned SAS_IN_WIDTH    = 32;
  // width of the position field on the output stream
  localparam int unsigned SAS_POS_WIDTH   = 6;
  // output tdata is the position padded to whole bytes
  localparam int unsigned SAS_OUT_WIDTH   = ((SAS_POS_WIDTH + 7) / 8) * 8;

endpackage

FILE: rtl/sas_mem.sv
// simple dual-port synchronous ram for the sorted store, one write and one read port
// read data registered; uses sas_pkg for default sizes
module sas_mem #(
  parameter int unsigned DEPTH = sas_pkg::SAS_MAX_ITEMS,
  parameter int unsigned WIDTH = sas_pkg::SAS_VALUE_WIDTH + sas_pkg::SAS_POS_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  import sas_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/stable_argsort.sv
// stable argsort top level: insertion control, emit sequencer, stream ports
// depends on sas_pkg and sas_mem
//
// usage
//   input stream (s_axis_*): one signed fitness value per request in tdata,
//   tlast marks the final value of a set. output stream (m_axis_*): after the
//   set is complete, the arrival positions in ascending order of value, one
//   per request, equal values in arrival order; tlast marks the final one and
//   tuser flags that more values arrived than the store holds.
// operation
//   each value is placed by insertion into a single ram: the read of the
//   top entry is issued when the value is accepted, then each stored entry
//   greater than it moves up one place, and the value is written into the
//   freed slot. a dropped value (store full) is only flagged. emitting reads
//   each entry from the ram, then loads its position into the output register
//   and holds it while the receiver stalls. the ram read latency sets both loops.
// reset
//   clears the item count and the overflow flag; ram contents need no reset.
// stalls
//   the result sits in the output register until taken; no new value is
//   accepted while a set is being emitted.
module stable_argsort #(
  parameter int unsigned MAX_ITEMS   = sas_pkg::SAS_MAX_ITEMS,
  parameter int unsigned VALUE_WIDTH = sas_pkg::SAS_VALUE_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input stream, tdata: value[31:0]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sas_pkg::SAS_IN_WIDTH-1:0]   s_axis_tdata,
  input  logic                               s_axis_tlast,
  // output stream, tdata: position[5:0], zero pad[7:6]; tuser: overflow
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sas_pkg::SAS_OUT_WIDTH-1:0]  m_axis_tdata,
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import sas_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned MW = VALUE_WIDTH + SAS_POS_WIDTH;

  // controller states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_ERD   = 3'd2;
  localparam logic [2:0] ST_ELOAD = 3'd3;
  localparam logic [2:0] ST_EWAIT = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [CW-1:0]                 count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic [AW-1:0]                 slot_q, slot_d;
  logic [AW-1:0]                 idx_q, idx_d;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic                          last_q, last_d;
  logic [SAS_POS_WIDTH-1:0]      opos_q, opos_d;
  logic                          olast_q, olast_d;
  logic                          oovf_q, oovf_d;

  logic                          we;
  logic [AW-1:0]                 waddr, raddr;
  logic [MW-1:0]                 wdata, rdata;
  logic signed [VALUE_WIDTH-1:0] rd_key;
  logic [AW-1:0]                 cnt_m1;
  logic                          in_req;
  logic                          full;

  sas_mem #(
    .DEPTH (MAX_ITEMS),
    .WIDTH (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_key = $signed(rdata[VALUE_WIDTH-1:0]);
  assign cnt_m1 = AW'(count_q - CW'(1));
  assign full   = (count_q == CW'(MAX_ITEMS));
  assign in_req = s_axis_tvalid && s_axis_tready;

  // stream outputs
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EWAIT);
  assign m_axis_tdata  = SAS_OUT_WIDTH'(opos_q);
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = oovf_q;

  // insertion and emit sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    slot_d  = slot_q;
    idx_d   = idx_q;
    key_d   = key_q;
    last_d  = last_q;
    opos_d  = opos_q;
    olast_d = olast_q;
    oovf_d  = oovf_q;
    we      = 1'b0;
    waddr   = slot_q;
    wdata   = {SAS_POS_WIDTH'(count_q), key_q};
    raddr   = cnt_m1;
    unique case (state_q)
      ST_IDLE: begin
        raddr = cnt_m1;
        if (in_req) begin
          if (full) begin
            // store full: drop the value, flag the set
            ovf_d = 1'b1;
            if (s_axis_tlast) begin
              idx_d   = '0;
              state_d = ST_ERD;
            end
          end else begin
            // start insertion at the tail, top entry read issued now
            key_d   = VALUE_WIDTH'($signed(s_axis_tdata));
            last_d  = s_axis_tlast;
            slot_d  = AW'(count_q);
            state_d = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        // read data holds entry slot-1 when slot is nonzero
        we    = 1'b1;
        waddr = slot_q;
        raddr = slot_q - AW'(2);
        if (slot_q != '0 && rd_key > key_q) begin
          // move the greater entry up one place, read the next one down
          wdata  = rdata;
          slot_d = slot_q - AW'(1);
        end else begin
          wdata   = {SAS_POS_WIDTH'(count_q), key_q};
          count_d = count_q + CW'(1);
          if (last_q) begin
            idx_d   = '0;
            state_d = ST_ERD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ERD: begin
        raddr   = idx_q;
        state_d = ST_ELOAD;
      end
      ST_ELOAD: begin
        // capture the entry into the output register
        raddr   = idx_q;
        opos_d  = rdata[MW-1:VALUE_WIDTH];
        olast_d = (idx_q == cnt_m1);
        oovf_d  = ovf_q;
        state_d = ST_EWAIT;
      end
      ST_EWAIT: begin
        raddr = idx_q + AW'(1);
        if (m_axis_tready) begin
          if (olast_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = ST_ELOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    idx_q   <= idx_d;
    key_q   <= key_d;
    last_q  <= last_d;
    opos_q  <= opos_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
  end

endmodule
